FILE: hw/rtl/s_expression_tokenizer_assert.svh
// Assertion macros for the S-expression tokenizer.
// Used by the top level; needs nothing else. They compile to nothing under SYNTHESIS.
`ifndef S_EXPRESSION_TOKENIZER_ASSERT_SVH
`define S_EXPRESSION_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SXT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");
// next-cycle implication
`define SXT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");
`else
`define SXT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SXT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/sxt_pkg.sv
// Types, codes and character classes of the S-expression tokenizer.
// Standalone; used by sxt_lexer and s_expression_tokenizer.
package sxt_pkg;

  localparam logic [2:0] KIND_LPAREN = 3'd0;
  localparam logic [2:0] KIND_RPAREN = 3'd1;
  localparam logic [2:0] KIND_SYMBOL = 3'd2;
  localparam logic [2:0] KIND_NUMBER = 3'd3;
  localparam logic [2:0] KIND_STRING = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;
  localparam logic [2:0] KIND_EOF    = 3'd6;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_NUM_LONG    = 3'd1;
  localparam logic [2:0] ERR_STR_LONG    = 3'd2;
  localparam logic [2:0] ERR_SYM_LONG    = 3'd3;
  localparam logic [2:0] ERR_UNTERM      = 3'd4;
  localparam logic [2:0] ERR_UNEXPECTED  = 3'd5;

  localparam logic [1:0] CLS_IDLE = 2'd0;
  localparam logic [1:0] CLS_SYM  = 2'd1;
  localparam logic [1:0] CLS_NUM  = 2'd2;
  localparam logic [1:0] CLS_STR  = 2'd3;

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [15:0] POS_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } char_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value_byte;
    logic        has_byte;
    logic        token_end;
    logic [2:0]  error_code;
    logic [15:0] line;
    logic [15:0] column;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } lex_out_t;

  typedef struct packed {
    tok_t       tok;
    logic [1:0] cls;
    logic [7:0] cnt;
  } step_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_sym(logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
        || (b == CH_STAR) || (b == CH_MINUS) || (b == CH_PLUS) || (b == CH_SLASH)
        || (b == CH_UNDER);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    // space, tab, newline, vertical tab, form feed, carriage return
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic tok_t make_tok(logic [2:0] kind, logic [7:0] b, logic has,
                                    logic fin, logic [2:0] err,
                                    logic [15:0] ln, logic [15:0] col);
    tok_t t;
    t.kind       = kind;
    t.value_byte = has ? b : 8'd0;
    t.has_byte   = has;
    t.token_end  = fin;
    t.error_code = err;
    t.line       = ln;
    t.column     = col;
    t.last       = 1'b0;
    return t;
  endfunction

endpackage

FILE: hw/rtl/sxt_lexer.sv
// Lexer state and per-word result logic of the S-expression tokenizer.
// Depends on sxt_pkg. Gives up to two results for the held word; commit advances the state.
module sxt_lexer #(
  parameter int SYMBOL_LIMIT = 64,
  parameter int NUMBER_LIMIT = 32,
  parameter int STRING_LIMIT = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  sxt_pkg::char_t   item,
  input  logic             commit,
  output sxt_pkg::lex_out_t res
);

  logic [1:0]  cls, cls_next;
  logic [7:0]  cnt, cnt_next;
  logic [15:0] line, line_next;
  logic [15:0] column, column_next;

  function automatic logic [7:0] limit_of(logic [1:0] c);
    unique case (c)
      sxt_pkg::CLS_SYM: limit_of = 8'(SYMBOL_LIMIT);
      sxt_pkg::CLS_NUM: limit_of = 8'(NUMBER_LIMIT);
      default:          limit_of = 8'(STRING_LIMIT);
    endcase
  endfunction

  function automatic logic [2:0] kind_of(logic [1:0] c);
    unique case (c)
      sxt_pkg::CLS_SYM: kind_of = sxt_pkg::KIND_SYMBOL;
      sxt_pkg::CLS_NUM: kind_of = sxt_pkg::KIND_NUMBER;
      default:          kind_of = sxt_pkg::KIND_STRING;
    endcase
  endfunction

  function automatic logic [2:0] err_of(logic [1:0] c);
    unique case (c)
      sxt_pkg::CLS_SYM: err_of = sxt_pkg::ERR_SYM_LONG;
      sxt_pkg::CLS_NUM: err_of = sxt_pkg::ERR_NUM_LONG;
      default:          err_of = sxt_pkg::ERR_STR_LONG;
    endcase
  endfunction

  // Append one character to a token of class c; end it with an error at the limit less one.
  function automatic sxt_pkg::step_t add_char(logic [1:0] c, logic [7:0] base, logic [7:0] b,
                                              logic [15:0] ln, logic [15:0] col);
    sxt_pkg::step_t s;
    logic [7:0] cnt1;
    logic       over;
    cnt1 = base + 8'd1;
    over = ({1'b0, cnt1} + 9'd1) >= {1'b0, limit_of(c)};
    if (over) begin
      s.tok = sxt_pkg::make_tok(sxt_pkg::KIND_ERROR, b, 1'b1, 1'b1, err_of(c), ln, col);
      s.cls = sxt_pkg::CLS_IDLE;
      s.cnt = 8'd0;
    end else begin
      s.tok = sxt_pkg::make_tok(kind_of(c), b, 1'b1, 1'b0, sxt_pkg::ERR_NONE, ln, col);
      s.cls = c;
      s.cnt = cnt1;
    end
    return s;
  endfunction

  logic [7:0]     b;
  logic           at_end;
  logic           idle_has;
  sxt_pkg::step_t idle_step;
  sxt_pkg::step_t cur_step;
  sxt_pkg::tok_t  close_tok;
  sxt_pkg::tok_t  eof_tok;

  assign b      = item.in_byte;
  assign at_end = item.is_end || (b == 8'd0);

  // Lex a byte with no token open.
  always_comb begin
    idle_has  = 1'b1;
    idle_step.tok = sxt_pkg::make_tok(sxt_pkg::KIND_ERROR, b, 1'b1, 1'b1,
                                      sxt_pkg::ERR_UNEXPECTED, line, column);
    idle_step.cls = sxt_pkg::CLS_IDLE;
    idle_step.cnt = 8'd0;
    priority if (sxt_pkg::is_space(b)) begin
      idle_has = 1'b0;
    end else if (b == sxt_pkg::CH_LPAREN) begin
      idle_step.tok = sxt_pkg::make_tok(sxt_pkg::KIND_LPAREN, b, 1'b1, 1'b1,
                                        sxt_pkg::ERR_NONE, line, column);
    end else if (b == sxt_pkg::CH_RPAREN) begin
      idle_step.tok = sxt_pkg::make_tok(sxt_pkg::KIND_RPAREN, b, 1'b1, 1'b1,
                                        sxt_pkg::ERR_NONE, line, column);
    end else if (b == sxt_pkg::CH_QUOTE) begin
      idle_has      = 1'b0;
      idle_step.cls = sxt_pkg::CLS_STR;
    end else if (sxt_pkg::is_digit(b)) begin
      idle_step = add_char(sxt_pkg::CLS_NUM, 8'd0, b, line, column);
    end else if (sxt_pkg::is_sym(b)) begin
      idle_step = add_char(sxt_pkg::CLS_SYM, 8'd0, b, line, column);
    end else begin
      idle_has = 1'b1;
    end
  end

  always_comb begin
    cur_step  = add_char(cls, cnt, b, line, column);
    close_tok = sxt_pkg::make_tok(kind_of(cls), 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_NONE,
                                  line, column);
    eof_tok   = sxt_pkg::make_tok(sxt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_NONE,
                                  line, column);
  end

  always_comb begin
    res.count  = 2'd0;
    res.first  = idle_step.tok;
    res.second = idle_step.tok;
    cls_next   = cls;
    cnt_next   = cnt;
    if (at_end) begin
      res.second = eof_tok;
      cls_next   = sxt_pkg::CLS_IDLE;
      cnt_next   = 8'd0;
      unique case (cls)
        sxt_pkg::CLS_IDLE: begin
          res.count = 2'd1;
          res.first = eof_tok;
        end
        sxt_pkg::CLS_STR: begin
          res.count = 2'd2;
          res.first = sxt_pkg::make_tok(sxt_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1,
                                        sxt_pkg::ERR_UNTERM, line, column);
        end
        default: begin
          res.count = 2'd2;
          res.first = close_tok;
        end
      endcase
    end else begin
      unique case (cls)
        sxt_pkg::CLS_IDLE: begin
          res.count = {1'b0, idle_has};
          cls_next  = idle_step.cls;
          cnt_next  = idle_step.cnt;
        end
        sxt_pkg::CLS_STR: begin
          if (b == sxt_pkg::CH_QUOTE) begin
            res.count = 2'd1;
            res.first = close_tok;
            cls_next  = sxt_pkg::CLS_IDLE;
            cnt_next  = 8'd0;
          end else begin
            res.count = 2'd1;
            res.first = cur_step.tok;
            cls_next  = cur_step.cls;
            cnt_next  = cur_step.cnt;
          end
        end
        default: begin
          // symbol or number: continue, or close and lex the byte afresh
          if ((cls == sxt_pkg::CLS_SYM) ? sxt_pkg::is_sym(b) : sxt_pkg::is_digit(b)) begin
            res.count = 2'd1;
            res.first = cur_step.tok;
            cls_next  = cur_step.cls;
            cnt_next  = cur_step.cnt;
          end else begin
            res.count  = idle_has ? 2'd2 : 2'd1;
            res.first  = close_tok;
            res.second = idle_step.tok;
            cls_next   = idle_step.cls;
            cnt_next   = idle_step.cnt;
          end
        end
      endcase
    end
  end

  always_comb begin
    line_next   = line;
    column_next = column;
    if (at_end) begin
      line_next   = 16'd1;
      column_next = 16'd1;
    end else if (b == sxt_pkg::CH_NEWLINE) begin
      if (line != sxt_pkg::POS_MAX) line_next = line + 16'd1;
      column_next = 16'd1;
    end else if (column != sxt_pkg::POS_MAX) begin
      column_next = column + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls    <= sxt_pkg::CLS_IDLE;
      cnt    <= 8'd0;
      line   <= 16'd1;
      column <= 16'd1;
    end else if (commit) begin
      cls    <= cls_next;
      cnt    <= cnt_next;
      line   <= line_next;
      column <= column_next;
    end
  end

endmodule

FILE: hw/rtl/s_expression_tokenizer.sv
// Top level of the S-expression tokenizer: input word register, result sequencing, output register.
// Depends on sxt_pkg, sxt_lexer and s_expression_tokenizer_assert.svh.
//
// Streaming S-expression lexer. Each char word carries one text byte (or an end marker; a
// zero byte also ends input) and yields zero, one or two tok words: token characters stream
// out as they arrive and a word with token_end set closes each token; last marks the final
// tok word of one char word. A char word that yields at most one tok word is dropped as
// that word loads, so a new char word is accepted every cycle while tok_ready holds. A char
// word that yields two (a closing word ahead of a delimiter, or a close/error ahead of end of
// file) holds the input register until both are loaded, since the single output register
// sends one tok word per cycle while tok_ready holds. After an end marker all state is reset,
// so a new stream can follow at once. No clearing pass is needed.
`include "s_expression_tokenizer_assert.svh"

module s_expression_tokenizer #(
  parameter int SYMBOL_LIMIT = 64,
  parameter int NUMBER_LIMIT = 32,
  parameter int STRING_LIMIT = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_ready,
  input  sxt_pkg::char_t char_data,
  output logic           tok_valid,
  input  logic           tok_ready,
  output sxt_pkg::tok_t  tok_data
);

  // input register
  logic              iv;
  sxt_pkg::char_t    item;
  // 1 while the second tok word of the held char word is due
  logic              phase;
  // output register
  logic              ov;
  sxt_pkg::tok_t     obuf;

  sxt_pkg::lex_out_t lex;
  sxt_pkg::tok_t     pick;
  logic              can_emit;
  logic              last_sel;
  logic              done;

  sxt_lexer #(
    .SYMBOL_LIMIT(SYMBOL_LIMIT),
    .NUMBER_LIMIT(NUMBER_LIMIT),
    .STRING_LIMIT(STRING_LIMIT)
  ) u_lexer (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .commit (done),
    .res    (lex)
  );

  // The output register frees up when empty or when its word is taken this cycle.
  assign can_emit = !ov || tok_ready;
  // The word going out now is the last one of the held char word.
  assign last_sel = phase || (lex.count == 2'd1);
  // Drop the held char word once all its tok words are loaded (or it has none).
  assign done = iv && ((lex.count == 2'd0) || (can_emit && last_sel));

  assign char_ready = !iv || done;

  always_comb begin
    pick      = phase ? lex.second : lex.first;
    pick.last = last_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv    <= 1'b0;
      phase <= 1'b0;
      ov    <= 1'b0;
    end else begin
      if (char_valid && char_ready) begin
        iv <= 1'b1;
      end else if (done) begin
        iv <= 1'b0;
      end
      // advance to the second word only when the first is loaded
      if (done) begin
        phase <= 1'b0;
      end else if (iv && can_emit && (lex.count == 2'd2)) begin
        phase <= 1'b1;
      end
      if (can_emit) begin
        ov <= iv && (lex.count != 2'd0);
      end
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      item <= char_data;
    end
    if (can_emit) begin
      obuf <= pick;
    end
  end

  assign tok_valid = ov;
  assign tok_data  = obuf;

  // checks
  `SXT_ASSERT_IMP(a_phase_held, clk, rst, phase, iv && (lex.count == 2'd2))
  `SXT_ASSERT_NXT(a_phase_adv, clk, rst,
                  iv && !phase && can_emit && (lex.count == 2'd2), phase)
  `SXT_ASSERT_IMP(a_eof_last, clk, rst,
                  tok_valid && (tok_data.kind == sxt_pkg::KIND_EOF),
                  tok_data.last && tok_data.token_end)
  `SXT_ASSERT_IMP(a_err_kind, clk, rst,
                  tok_valid && (tok_data.error_code != sxt_pkg::ERR_NONE),
                  (tok_data.kind == sxt_pkg::KIND_ERROR) && tok_data.token_end)

endmodule

FILE: tb/s_expression_tokenizer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for s_expression_tokenizer: random char words in, tok words checked.
// Depends on sxt_pkg and the s_expression_tokenizer RTL.
module s_expression_tokenizer_test;

  localparam int SYM_MAX = 64;
  localparam int NUM_MAX = 32;
  localparam int STR_MAX = 128;

  localparam logic [7:0] CH_VTAB  = 8'h0B;
  localparam logic [7:0] CH_FFEED = 8'h0C;

  // Symbol alphabet: letters first, then digits, then the five operator marks.
  localparam string SYM_SET =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789*-+/_";

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           char_valid = 1'b0;
  logic           char_ready;
  sxt_pkg::char_t char_data = '0;
  logic           tok_valid;
  logic           tok_ready = 1'b0;
  sxt_pkg::tok_t  tok_data;

  s_expression_tokenizer #(
    .SYMBOL_LIMIT(SYM_MAX),
    .NUMBER_LIMIT(NUM_MAX),
    .STRING_LIMIT(STR_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_data(char_data),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok_data(tok_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sxt_pkg::char_t pending_chars[$];
  sxt_pkg::tok_t  expected_toks[$];
  int    total_chars = 0;
  int    chars_sent = 0;
  int    mismatches = 0;
  int    toks_seen = 0;
  logic  quiet_tail;

  // Drop all idling once the last stretch of the stimulus is being offered.
  assign quiet_tail = (chars_sent + 200 >= total_chars);

  // ---------------------------------------------------------------------------
  // Lexer predictor: its own copy of the token state and the text position.
  // ---------------------------------------------------------------------------
  logic [1:0]  tk_class = sxt_pkg::CLS_IDLE;
  logic [7:0]  tk_len = 8'd0;
  logic [15:0] cur_line = 16'd1;
  logic [15:0] cur_col = 16'd1;

  function automatic logic digit_byte(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic word_byte(logic [7:0] b);
    logic [7:0] low;
    low = b | 8'h20;
    if (digit_byte(b) || (low >= "a" && low <= "z"))
      return 1'b1;
    return b == sxt_pkg::CH_STAR || b == sxt_pkg::CH_MINUS || b == sxt_pkg::CH_PLUS
        || b == sxt_pkg::CH_SLASH || b == sxt_pkg::CH_UNDER;
  endfunction

  function automatic logic blank_byte(logic [7:0] b);
    case (b)
      sxt_pkg::CH_SPACE, sxt_pkg::CH_TAB, sxt_pkg::CH_NEWLINE, CH_VTAB, CH_FFEED,
      sxt_pkg::CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [2:0] class_kind(logic [1:0] cls);
    case (cls)
      sxt_pkg::CLS_SYM: return sxt_pkg::KIND_SYMBOL;
      sxt_pkg::CLS_NUM: return sxt_pkg::KIND_NUMBER;
      default: return sxt_pkg::KIND_STRING;
    endcase
  endfunction

  // Append one expected tok word at the position of the byte being lexed.
  task automatic push_tok(logic [2:0] kind, logic [7:0] b, logic has, logic fin,
                          logic [2:0] err);
    sxt_pkg::tok_t t;
    t.kind       = kind;
    t.value_byte = has ? b : 8'd0;
    t.has_byte   = has;
    t.token_end  = fin;
    t.error_code = err;
    t.line       = cur_line;
    t.column     = cur_col;
    t.last       = 1'b0;
    expected_toks.push_back(t);
  endtask

  // Add a character to the open token; the one that reaches its cap less one is an error.
  task automatic grow_token(logic [7:0] b);
    int         cap;
    logic [2:0] err;
    case (tk_class)
      sxt_pkg::CLS_SYM: begin
        cap = SYM_MAX;
        err = sxt_pkg::ERR_SYM_LONG;
      end
      sxt_pkg::CLS_NUM: begin
        cap = NUM_MAX;
        err = sxt_pkg::ERR_NUM_LONG;
      end
      default: begin
        cap = STR_MAX;
        err = sxt_pkg::ERR_STR_LONG;
      end
    endcase
    tk_len = tk_len + 8'd1;
    if (int'(tk_len) + 1 >= cap) begin
      push_tok(sxt_pkg::KIND_ERROR, b, 1'b1, 1'b1, err);
      tk_class = sxt_pkg::CLS_IDLE;
      tk_len = 8'd0;
    end else begin
      push_tok(class_kind(tk_class), b, 1'b1, 1'b0, sxt_pkg::ERR_NONE);
    end
  endtask

  // Lex a byte with no token open.
  task automatic start_token(logic [7:0] b);
    if (blank_byte(b)) begin
      // whitespace only moves the position
    end else if (b == sxt_pkg::CH_LPAREN) begin
      push_tok(sxt_pkg::KIND_LPAREN, b, 1'b1, 1'b1, sxt_pkg::ERR_NONE);
    end else if (b == sxt_pkg::CH_RPAREN) begin
      push_tok(sxt_pkg::KIND_RPAREN, b, 1'b1, 1'b1, sxt_pkg::ERR_NONE);
    end else if (b == sxt_pkg::CH_QUOTE) begin
      tk_class = sxt_pkg::CLS_STR;
      tk_len = 8'd0;
    end else if (digit_byte(b)) begin
      tk_class = sxt_pkg::CLS_NUM;
      tk_len = 8'd0;
      grow_token(b);
    end else if (word_byte(b)) begin
      tk_class = sxt_pkg::CLS_SYM;
      tk_len = 8'd0;
      grow_token(b);
    end else begin
      push_tok(sxt_pkg::KIND_ERROR, b, 1'b1, 1'b1, sxt_pkg::ERR_UNEXPECTED);
    end
  endtask

  // Predict the tok words of one accepted char word.
  task automatic lex_char(sxt_pkg::char_t c);
    logic [7:0] b;
    int         first;
    b = c.in_byte;
    first = expected_toks.size();
    if (c.is_end || b == 8'd0) begin
      // end of input: close or flag the open token, then end of file, then restart
      if (tk_class == sxt_pkg::CLS_STR)
        push_tok(sxt_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_UNTERM);
      else if (tk_class != sxt_pkg::CLS_IDLE)
        push_tok(class_kind(tk_class), 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_NONE);
      push_tok(sxt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_NONE);
      tk_class = sxt_pkg::CLS_IDLE;
      tk_len = 8'd0;
      cur_line = 16'd1;
      cur_col = 16'd1;
    end else begin
      case (tk_class)
        sxt_pkg::CLS_SYM, sxt_pkg::CLS_NUM: begin
          if (tk_class == sxt_pkg::CLS_SYM ? word_byte(b) : digit_byte(b)) begin
            grow_token(b);
          end else begin
            // delimiter: close the token, then lex the byte afresh
            push_tok(class_kind(tk_class), 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_NONE);
            tk_class = sxt_pkg::CLS_IDLE;
            tk_len = 8'd0;
            start_token(b);
          end
        end
        sxt_pkg::CLS_STR: begin
          if (b == sxt_pkg::CH_QUOTE) begin
            push_tok(sxt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_NONE);
            tk_class = sxt_pkg::CLS_IDLE;
            tk_len = 8'd0;
          end else begin
            grow_token(b);
          end
        end
        default: start_token(b);
      endcase
      if (b == sxt_pkg::CH_NEWLINE) begin
        if (cur_line != sxt_pkg::POS_MAX)
          cur_line = cur_line + 16'd1;
        cur_col = 16'd1;
      end else if (cur_col != sxt_pkg::POS_MAX) begin
        cur_col = cur_col + 16'd1;
      end
    end
    if (expected_toks.size() > first)
      expected_toks[expected_toks.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] tok word %0d: %s is %0d, predicted %0d", $realtime, toks_seen, field,
             got, want);
    mismatches++;
  endtask

  task automatic check_tok(sxt_pkg::tok_t got);
    sxt_pkg::tok_t want;
    toks_seen++;
    if (expected_toks.size() == 0) begin
      report_mismatch("unpredicted word, kind", int'(got.kind), -1);
      return;
    end
    want = expected_toks.pop_front();
    if (got.kind !== want.kind)
      report_mismatch("kind", int'(got.kind), int'(want.kind));
    if (got.value_byte !== want.value_byte)
      report_mismatch("value_byte", int'(got.value_byte), int'(want.value_byte));
    if (got.has_byte !== want.has_byte)
      report_mismatch("has_byte", int'(got.has_byte), int'(want.has_byte));
    if (got.token_end !== want.token_end)
      report_mismatch("token_end", int'(got.token_end), int'(want.token_end));
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", int'(got.error_code), int'(want.error_code));
    if (got.line !== want.line)
      report_mismatch("line", int'(got.line), int'(want.line));
    if (got.column !== want.column)
      report_mismatch("column", int'(got.column), int'(want.column));
    if (got.last !== want.last)
      report_mismatch("last", int'(got.last), int'(want.last));
  endtask

  // Monitor: predict on every accepted char word, then check every accepted tok word.
  // Both run in one process so the queue is never touched by two blocks in one step.
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && char_ready)
        lex_char(char_data);
      if (tok_valid && tok_ready)
        check_tok(tok_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver
  // ---------------------------------------------------------------------------

  // Idle odds for the next stretch: none, or a burst start at odds of 1 in 3, 8 or 20.
  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 20;
    endcase
  endfunction

  int tx_tick = 0;
  int tx_odds = 0;
  int tx_gap = 0;

  // Hold the word until accepted; between words, insert random idle bursts.
  always @(posedge clk) begin
    tx_tick++;
    if (tx_tick % 128 == 0)
      tx_odds = pick_odds();
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_ready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        char_valid <= 1'b0;
      end else if (pending_chars.size() == 0) begin
        char_valid <= 1'b0;
      end else if (!quiet_tail && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
        tx_gap = $urandom_range(0, 18);
        char_valid <= 1'b0;
      end else begin
        char_data <= pending_chars.pop_front();
        char_valid <= 1'b1;
        chars_sent <= chars_sent + 1;
      end
    end
  end

  int   rx_tick = 0;
  int   rx_odds = 0;
  int   rx_gap = 0;
  int   rx_hold = 0;
  logic held_off = 1'b0;

  // Stall the output in random bursts; once, hold it off so that the block fills up
  // and has to drop char_ready while words keep being offered.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 128 == 0)
      rx_odds = pick_odds();
    if (rst) begin
      tok_ready <= 1'b0;
    end else if (!held_off && chars_sent >= 300) begin
      held_off = 1'b1;
      rx_hold = 299;
      tok_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      tok_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      tok_ready <= 1'b0;
    end else if (!quiet_tail && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      rx_gap = $urandom_range(0, 18);
      tok_ready <= 1'b0;
    end else begin
      tok_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] b);
    sxt_pkg::char_t c;
    c.in_byte = b;
    c.is_end  = 1'b0;
    pending_chars.push_back(c);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i]);
  endtask

  // End marker; the byte rides along and must be ignored.
  task automatic queue_end(logic [7:0] b);
    sxt_pkg::char_t c;
    c.in_byte = b;
    c.is_end  = 1'b1;
    pending_chars.push_back(c);
  endtask

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 7))
      0, 1, 2: return sxt_pkg::CH_SPACE;
      3: return sxt_pkg::CH_TAB;
      4: return sxt_pkg::CH_NEWLINE;
      5: return CH_VTAB;
      6: return CH_FFEED;
      default: return sxt_pkg::CH_CR;
    endcase
  endfunction

  // Mostly short tokens; now and then one right around the too-long boundary.
  function automatic int token_len(int cap);
    if ($urandom_range(0, 24) == 0)
      return cap - 3 + $urandom_range(0, 5);
    return $urandom_range(1, 6);
  endfunction

  task automatic queue_symbol(int n);
    int r;
    // first character anything but a digit
    r = $urandom_range(0, 56);
    queue_byte(SYM_SET[r < 52 ? r : r + 10]);
    for (int i = 1; i < n; i++)
      queue_byte(SYM_SET[$urandom_range(0, SYM_SET.len() - 1)]);
  endtask

  task automatic queue_number(int n);
    for (int i = 0; i < n; i++)
      queue_byte(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  task automatic queue_string(int n);
    logic [7:0] b;
    queue_byte(sxt_pkg::CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0: b = 8'($urandom_range(1, 255));
        1: b = sxt_pkg::CH_NEWLINE;
        default: b = 8'($urandom_range(8'h20, 8'h7E));
      endcase
      if (b == sxt_pkg::CH_QUOTE)
        b = "q";
      queue_byte(b);
    end
    queue_byte(sxt_pkg::CH_QUOTE);
  endtask

  // A parenthesized list of atoms and nested lists.
  task automatic queue_expr(int depth);
    int k;
    k = $urandom_range(1, 6);
    queue_byte(sxt_pkg::CH_LPAREN);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 3) != 0)
        queue_byte(rand_blank());
      case ($urandom_range(0, 4))
        0, 1: queue_symbol(token_len(SYM_MAX));
        2: queue_number(token_len(NUM_MAX));
        3: queue_string(token_len(STR_MAX));
        default: begin
          if (depth > 0)
            queue_expr(depth - 1);
          else
            queue_symbol(1);
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0)
      queue_byte(rand_blank());
    queue_byte(sxt_pkg::CH_RPAREN);
  endtask

  // Random mix: mostly well-formed lists, some noise, broken tokens and stream ends.
  task automatic queue_random(int count);
    int target;
    target = pending_chars.size() + count;
    while (pending_chars.size() < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          repeat ($urandom_range(1, 8))
            queue_byte(8'($urandom_range(0, 255)));
        end
        3: begin
          queue_byte(sxt_pkg::CH_QUOTE);
          queue_symbol(3);
          queue_end(8'($urandom_range(0, 255)));
        end
        4: begin
          queue_symbol(2);
          queue_end(8'($urandom_range(0, 255)));
        end
        5: begin
          queue_number(3);
          queue_byte(8'd0);
        end
        6: begin
          if ($urandom_range(0, 1) == 0)
            queue_end(8'($urandom_range(0, 255)));
          else
            queue_byte(8'd0);
        end
        default: queue_expr(2);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // Directed: parens, every symbol mark, a number closed by a paren, a string
    // holding a newline, an empty string, unexpected characters, an open string
    // at the end marker, and an open number ended by a zero byte.
    queue_text("(ab+-*/_Z 7)");
    queue_text("\"q\n\"\"\"#");
    queue_byte(8'hFF);
    queue_text("\"z");
    queue_end(8'h41);
    queue_text("5");
    queue_byte(8'h00);

    queue_random(500);

    // A few tokens across a line break, then an end marker.
    queue_text("ab\n");
    queue_text("x 12 (\"s\")");
    queue_end(8'($urandom_range(0, 255)));

    queue_random(600);
    total_chars = pending_chars.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge, clear of the monitor's updates.
    @(negedge clk);
    while (pending_chars.size() != 0 || char_valid || expected_toks.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sxt_pkg.sv
hw/rtl/sxt_lexer.sv
hw/rtl/s_expression_tokenizer.sv
tb/s_expression_tokenizer_test.sv
